// File: hdl/binary_code_autocorrelation_scorer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary code autocorrelation scorer
// Shared concurrent-assertion forms, clocked and gated by the block reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_CODE_AUTOCORRELATION_SCORER_ASSERT_SVH
`define BINARY_CODE_AUTOCORRELATION_SCORER_ASSERT_SVH

// Same-cycle implication: cons must hold at every edge where ante holds.
`define BCAS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcas: same-cycle check failed");

// Next-cycle implication: cons must hold at the edge after the one where ante holds.
`define BCAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcas: next-cycle check failed");

`endif

// File: hdl/bcas_pkg.sv
// ----------------------------------------------------------------------------
// bcas_pkg
// Constants and types shared by the autocorrelation scorer modules.
// ----------------------------------------------------------------------------
package bcas_pkg;

    // longest code word handled; lengths above it saturate
    localparam int C_MAX_LEN  = 32;
    localparam int C_CHIP_W   = 32;
    localparam int C_CFG_W    = 6;
    localparam int C_NUM_LAGS = C_MAX_LEN - 1;

    // internal length and per-lag agreement count widths
    localparam int C_LEN_W = $clog2(C_MAX_LEN + 1);
    localparam int C_CNT_W = $clog2(C_MAX_LEN + 1);
    localparam int C_CMP_W = C_LEN_W + 1;

    localparam int C_SCORE_W = 6;
    localparam int C_PEAK_W  = 6;
    localparam int C_SEC_W   = 5;

    localparam logic [C_CFG_W-1:0] C_LEN_RST = C_CFG_W'(13);

    typedef logic [C_MAX_LEN-1:0] t_chip_vec;
    typedef logic [C_CNT_W-1:0]   t_cnt;
    typedef logic [C_LEN_W-1:0]   t_len;

endpackage

// File: hdl/binary_code_autocorrelation_scorer.sv
// ----------------------------------------------------------------------------
// binary_code_autocorrelation_scorer
// Scores one candidate binary code word per cycle by its aperiodic
// autocorrelation: main peak, largest positive sidelobe, and their gap.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: pulse i_cfg_wr_en with the chip count on i_cfg_wr_data
//   (1..32, larger values saturate to 32, zero yields an all-zero result).
//   Write it only while no transfer is in flight. Reset loads 13.
//   Input channel: i_in_valid / o_in_stall carry one code word per transfer
//   on i_code_chips, bit i being chip i (set = +1, clear = -1).
//   Output channel: o_out_valid / i_out_stall carry one result per input
//   transfer: o_main_peak, o_second_value and o_score. A word whose largest
//   positive sidelobe exceeds one is rejected and reports all zeros.
//   Pipeline: four register stages (stage 1, stage 2, stage 3, output).
//   Throughput: one word per cycle while not stalled; every lag is computed in
//   its own lane, so the per-lane popcount tree sets the stage depth.
//   Stall: while the output register holds an untaken result and
//   i_out_stall is high, the whole pipeline freezes and o_in_stall is raised;
//   nothing is dropped or repeated.
//   Reset (synchronous, active low) empties the pipeline and reloads the
//   length register.
// ----------------------------------------------------------------------------
`include "binary_code_autocorrelation_scorer_assert.svh"

module binary_code_autocorrelation_scorer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [bcas_pkg::C_CFG_W-1:0]      i_cfg_wr_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [bcas_pkg::C_CHIP_W-1:0]     i_code_chips,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [bcas_pkg::C_SCORE_W-1:0]    o_score,
    output logic [bcas_pkg::C_PEAK_W-1:0]     o_main_peak,
    output logic [bcas_pkg::C_SEC_W-1:0]      o_second_value
);

    localparam int C_NL = bcas_pkg::C_NUM_LAGS;

    // configured length
    logic [bcas_pkg::C_CFG_W-1:0] r_code_length;

    // stage 1: captured word and clamped length
    logic                 r_s1_vld;
    bcas_pkg::t_chip_vec  r_s1_word;
    bcas_pkg::t_len       r_s1_len;
    bcas_pkg::t_chip_vec  n_s1_word;
    bcas_pkg::t_len       n_s1_len;

    // stage 2: per-lag agreement vectors (lag 0 is the peak itself)
    logic                 r_s2_vld;
    bcas_pkg::t_chip_vec  r_s2_lane [1:C_NL];
    bcas_pkg::t_chip_vec  n_s2_lane [1:C_NL];
    bcas_pkg::t_len       r_s2_len;

    // stage 3: per-lag agreement counts
    logic                 r_s3_vld;
    bcas_pkg::t_cnt       r_s3_cnt [1:C_NL];
    bcas_pkg::t_cnt       w_cnt    [1:C_NL];
    bcas_pkg::t_len       r_s3_len;

    // output register
    logic                               r_out_vld;
    logic [bcas_pkg::C_SCORE_W-1:0]     r_score;
    logic [bcas_pkg::C_PEAK_W-1:0]      r_peak;
    logic [bcas_pkg::C_SEC_W-1:0]       r_second;
    logic [bcas_pkg::C_SCORE_W-1:0]     n_score;
    logic [bcas_pkg::C_PEAK_W-1:0]      n_peak;
    logic [bcas_pkg::C_SEC_W-1:0]       n_second;

    logic w_adv;

    // Advance every stage together unless the held result is being stalled.
    assign w_adv      = !(r_out_vld && i_out_stall);
    assign o_in_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_length <= bcas_pkg::C_LEN_RST;
        end else if (i_cfg_wr_en) begin
            r_code_length <= i_cfg_wr_data;
        end
    end

    // Stage 1: capture the word, saturate the length. Chips past the input
    // word read as clear bits.
    always_comb begin
        n_s1_word = bcas_pkg::C_MAX_LEN'({{bcas_pkg::C_MAX_LEN{1'b0}}, i_code_chips});
        if (int'(r_code_length) > bcas_pkg::C_MAX_LEN) begin
            n_s1_len = bcas_pkg::C_LEN_W'(bcas_pkg::C_MAX_LEN);
        end else begin
            n_s1_len = bcas_pkg::C_LEN_W'(r_code_length);
        end
    end

    // Stage 2: chip j agrees with chip j+lag when the bits match; keep only
    // pairs that overlap inside the code word. The sidelobe at lag -l equals
    // the one at +l, so only positive lags are formed.
    always_comb begin
        for (int l = 1; l <= C_NL; l++) begin
            for (int j = 0; j < bcas_pkg::C_MAX_LEN; j++) begin
                n_s2_lane[l][j] = 1'b0;
                if (j + l < bcas_pkg::C_MAX_LEN) begin
                    if (int'(r_s1_len) > j + l) begin
                        n_s2_lane[l][j] = ~(r_s1_word[j] ^ r_s1_word[j+l]);
                    end
                end
            end
        end
    end

    // Stage 3: count agreements per lane.
    genvar g_l;
    generate
        for (g_l = 1; g_l <= C_NL; g_l++) begin : g_lane
            bcas_popcount u_popcount (
                .i_bits  (r_s2_lane[g_l]),
                .o_count (w_cnt[g_l])
            );
        end
    endgenerate

    // Output stage: sidelobe = 2*agree - overlap. Flag any sidelobe above one
    // (reject) and any equal to one. The zero-lag peak equals the length and
    // always exceeds every sidelobe.
    always_comb begin
        logic                           v_gt1;
        logic                           v_eq1;
        logic [bcas_pkg::C_CMP_W-1:0]   v_twice;
        logic [bcas_pkg::C_CMP_W-1:0]   v_ovl1;
        v_gt1   = 1'b0;
        v_eq1   = 1'b0;
        v_twice = '0;
        v_ovl1  = '0;
        for (int l = 1; l <= C_NL; l++) begin
            v_twice = bcas_pkg::C_CMP_W'({r_s3_cnt[l], 1'b0});
            v_ovl1  = bcas_pkg::C_CMP_W'(r_s3_len) - bcas_pkg::C_CMP_W'(l)
                    + bcas_pkg::C_CMP_W'(1);
            if (int'(r_s3_len) > l) begin
                if (v_twice > v_ovl1) begin
                    v_gt1 = 1'b1;
                end
                if (v_twice == v_ovl1) begin
                    v_eq1 = 1'b1;
                end
            end
        end
        if (v_gt1) begin
            n_peak   = '0;
            n_second = '0;
        end else begin
            n_peak   = bcas_pkg::C_PEAK_W'(r_s3_len);
            n_second = bcas_pkg::C_SEC_W'(v_eq1);
        end
        n_score = bcas_pkg::C_SCORE_W'(n_peak) - bcas_pkg::C_SCORE_W'(n_second);
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld  <= i_in_valid;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_out_vld <= r_s3_vld;
        end
    end

    // Payload; hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_word <= n_s1_word;
            r_s1_len  <= n_s1_len;
            r_s2_lane <= n_s2_lane;
            r_s2_len  <= r_s1_len;
            r_s3_cnt  <= w_cnt;
            r_s3_len  <= r_s2_len;
            r_score   <= n_score;
            r_peak    <= n_peak;
            r_second  <= n_second;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_score        = r_score;
    assign o_main_peak    = r_peak;
    assign o_second_value = r_second;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BCAS_ASSERT_NOW(a_second_le_one, i_clk, i_rst_n, o_out_valid, o_second_value <= 5'd1)
    `BCAS_ASSERT_NOW(a_reject_all_zero, i_clk, i_rst_n, o_out_valid && (o_main_peak == 6'd0), (o_score == 6'd0) && (o_second_value == 5'd0))
    `BCAS_ASSERT_NOW(a_stall_backpressure, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall)
    `BCAS_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_s1_vld)

endmodule

// File: hdl/bcas_popcount.sv
// ----------------------------------------------------------------------------
// bcas_popcount
// Balanced adder tree that counts the set bits of one lag lane.
// ----------------------------------------------------------------------------
module bcas_popcount (
    input  bcas_pkg::t_chip_vec i_bits,
    output bcas_pkg::t_cnt      o_count
);

    localparam int C_LVLS = $clog2(bcas_pkg::C_MAX_LEN);
    localparam int C_PAD  = 1 << C_LVLS;

    bcas_pkg::t_cnt w_sum [0:C_LVLS][0:C_PAD-1];

    genvar g_i, g_k;
    generate
        for (g_i = 0; g_i < C_PAD; g_i++) begin : g_leaf
            if (g_i < bcas_pkg::C_MAX_LEN) begin : g_bit
                assign w_sum[0][g_i] = bcas_pkg::C_CNT_W'(i_bits[g_i]);
            end else begin : g_pad
                assign w_sum[0][g_i] = '0;
            end
        end
        for (g_k = 0; g_k < C_LVLS; g_k++) begin : g_lvl
            for (g_i = 0; g_i < (C_PAD >> (g_k + 1)); g_i++) begin : g_add
                assign w_sum[g_k+1][g_i] = w_sum[g_k][2*g_i] + w_sum[g_k][2*g_i+1];
            end
        end
    endgenerate

    assign o_count = w_sum[C_LVLS][0];

endmodule
